>>> rtl/core/pvcc_pkg.sv
// ----------------------------------------------------------------------------
// pvcc_pkg
// shared widths, constants and types of the phase volume cell classifier
// ----------------------------------------------------------------------------
package pvcc_pkg;

    // field widths
    localparam int ENERGY_W = 32;
    localparam int MOMENT_W = 31;
    localparam int CFG_W    = 32;
    localparam int VOL_W    = 48;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 11;

    // defaults and fixed constants
    localparam int unsigned MAX_CELLS_DEFAULT = 1024;
    localparam int unsigned COUNT_SAT_MAX     = 2047;
    localparam logic [CFG_W-1:0] INV_REF_FIELD_RESET = 32'h0001_0000;
    // 4*pi/3*sqrt(2) in Q16.16
    localparam logic [31:0] VOL_COEFF_Q16 = 32'd388225;
    // rounding offset for the final divide by 2^16
    localparam logic [77:0] ROUND_HALF = 78'h8000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_CHECK,
        ST_SQRT,
        ST_SCALE,
        ST_SIGN,
        ST_DONE
    } state_t;

    // micro-ops of the shared multiplier
    typedef enum logic [3:0] {
        OP_MF0,
        OP_MF1,
        OP_M0_LO,
        OP_M0_HI,
        OP_M1_LO,
        OP_M1_HI,
        OP_TERM,
        OP_VOL_LO,
        OP_VOL_HI
    } op_t;

    typedef struct packed {
        logic [47:0] rem;
        logic [47:0] root;
    } sqrt_state_t;

    // one step of the restoring square root
    function automatic sqrt_state_t sqrt_step(input sqrt_state_t s, input logic [47:0] one);
        sqrt_state_t r;
        logic [48:0] trial;
        trial = {1'b0, s.root} + {1'b0, one};
        if ({1'b0, s.rem} >= trial) begin
            r.rem  = s.rem - trial[47:0];
            r.root = (s.root >> 1) + one;
        end
        else begin
            r.rem  = s.rem;
            r.root = s.root >> 1;
        end
        return r;
    endfunction

endpackage

>>> rtl/core/pvcc_if.sv
// ----------------------------------------------------------------------------
// pvcc interfaces
// valid/ready channels for cell items and cell results
// ----------------------------------------------------------------------------
interface pvcc_item_if import pvcc_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic signed [ENERGY_W-1:0]  band_low_energy;
    logic signed [ENERGY_W-1:0]  band_high_energy;
    logic signed [ENERGY_W-1:0]  potential;
    logic        [MOMENT_W-1:0]  moment_low;
    logic        [MOMENT_W-1:0]  moment_high;
    logic        [MOMENT_W-1:0]  field_strength;
    logic                        last_in_band;
    logic                        last_in_point;

    modport source (
        output valid, band_low_energy, band_high_energy, potential,
               moment_low, moment_high, field_strength, last_in_band, last_in_point,
        input  ready
    );
    modport sink (
        input  valid, band_low_energy, band_high_energy, potential,
               moment_low, moment_high, field_strength, last_in_band, last_in_point,
        output ready
    );
endinterface

interface pvcc_result_if import pvcc_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [VOL_W-1:0]    cell_volume;
    logic        [STATUS_W-1:0] cell_status;
    logic signed [VOL_W-1:0]    band_volume;
    logic        [COUNT_W-1:0]  band_active_cells;
    logic        [COUNT_W-1:0]  point_active_cells;
    logic                       band_done;
    logic                       point_done;

    modport source (
        output valid, cell_volume, cell_status, band_volume, band_active_cells,
               point_active_cells, band_done, point_done,
        input  ready
    );
    modport sink (
        input  valid, cell_volume, cell_status, band_volume, band_active_cells,
               point_active_cells, band_done, point_done,
        output ready
    );
endinterface

>>> rtl/core/phase_volume_cell_classifier_top.sv
// ----------------------------------------------------------------------------
// phase_volume_cell_classifier_top
// phase-space cell volume, activity status and band/point totals
// ----------------------------------------------------------------------------
// usage
//   item   : one cell per beat (energy edges, potential, moment edges, field,
//            end-of-band and end-of-point marks)
//   result : one beat per item (cell volume, status, band/point totals)
//   cfg    : cfg_wr_en/cfg_wr_data write inverse_ref_field, only while idle
// datapath and pacing
//   one cell passes through the shared 32x32 multiplier (twelve products at
//   most) and the square root unit (two root bits per cycle); the next item
//   is taken once the result is loaded, so one cell is in work at a time
// reset
//   rst_n clears the sequencer, the result valid, the band sum and both
//   counts, and loads inverse_ref_field with 1.0
// stall
//   a finished result waits in the output register; the next item is taken
//   meanwhile, but its result is held in the final step until the slot frees
// ----------------------------------------------------------------------------
module phase_volume_cell_classifier_top
    import pvcc_pkg::*;
#(
    parameter int unsigned MAX_CELLS_PER_POINT = MAX_CELLS_DEFAULT
)(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data,
    pvcc_item_if.sink        item,
    pvcc_result_if.source    result
);

    // count saturation point
    localparam int unsigned CountCap = (MAX_CELLS_PER_POINT > COUNT_SAT_MAX) ?
                                       COUNT_SAT_MAX : MAX_CELLS_PER_POINT;
    localparam logic [COUNT_W-1:0] CountCapL = COUNT_W'(CountCap);

    localparam logic signed [VOL_W:0] SumMax = {2'b00, {(VOL_W-1){1'b1}}};
    localparam logic signed [VOL_W:0] SumMin = {2'b11, {(VOL_W-1){1'b0}}};

    // sequencer
    state_t      state_reg, state_next;
    op_t         op_reg, op_next;
    logic [1:0]  pair_reg, pair_next;

    // configuration
    logic [CFG_W-1:0] irf_reg;

    // captured item
    logic signed [32:0]         k0_reg, k1_reg;
    logic [MOMENT_W-1:0]        mlo_reg, mhi_reg, fld_reg;
    logic                       last_band_reg, last_point_reg;

    // datapath
    logic [45:0]                mf0_reg, mf1_reg;
    logic [61:0]                m0_reg, m1_reg;
    logic [77:0]                acc_reg;
    logic [63:0]                prod_reg;
    logic [31:0]                d_reg;
    logic                       term_neg_reg;
    logic [47:0]                sq_one_reg;
    sqrt_state_t                sq_reg;
    logic signed [42:0]         sum_reg;
    logic                       sum_neg_reg;
    logic [41:0]                mag_reg;
    logic [44:0]                vol_mag_reg;
    logic signed [VOL_W-1:0]    vol_reg;
    logic [STATUS_W-1:0]        status_reg;

    // running totals
    logic signed [VOL_W-1:0]    band_sum_reg;
    logic [COUNT_W-1:0]         band_cnt_reg, point_cnt_reg;

    // result slot
    logic                       out_valid_reg;
    logic signed [VOL_W-1:0]    out_vol_reg, out_band_vol_reg;
    logic [STATUS_W-1:0]        out_status_reg;
    logic [COUNT_W-1:0]         out_band_cnt_reg, out_point_cnt_reg;
    logic                       out_band_done_reg, out_point_done_reg;

    // combinational helpers
    logic               item_beat, result_beat, slot_free;
    logic [31:0]        mul_a, mul_b;
    logic [77:0]        acc_sum;
    logic signed [32:0] k_sel;
    logic [61:0]        m_sel;
    logic               pair_taken;
    logic [31:0]        d_val;
    sqrt_state_t        sq_step1, sq_step2;
    logic               active, band_end;
    logic signed [VOL_W:0]      bsum_wide;
    logic signed [VOL_W-1:0]    bsum_new;
    logic [COUNT_W-1:0]         bcnt_new, pcnt_new;

    assign item_beat   = item.valid & item.ready;
    assign result_beat = result.valid & result.ready;
    assign slot_free   = !out_valid_reg || result.ready;

    // upper partial products land 32 bits up
    assign acc_sum = acc_reg + {prod_reg[45:0], 32'd0};

    // pair order: (k0,m0) minus, (k1,m0) plus, (k0,m1) plus, (k1,m1) minus
    assign k_sel      = pair_reg[0] ? k1_reg : k0_reg;
    assign m_sel      = pair_reg[1] ? m1_reg : m0_reg;
    assign pair_taken = !k_sel[32] && (k_sel != 33'sd0) &&
                        ({30'd0, k_sel[31:0]} > m_sel);
    assign d_val      = k_sel[31:0] - m_sel[31:0];

    // two root bits per cycle
    assign sq_step1 = sqrt_step(sq_reg, sq_one_reg);
    assign sq_step2 = sqrt_step(sq_step1, sq_one_reg >> 2);

    // totals update at the end of a cell
    assign active    = (status_reg != '0);
    assign band_end  = last_band_reg | last_point_reg;
    assign bsum_wide = {band_sum_reg[VOL_W-1], band_sum_reg} + {vol_reg[VOL_W-1], vol_reg};

    always_comb
    begin
        if (!active) begin
            bsum_new = band_sum_reg;
        end
        else if (bsum_wide > SumMax) begin
            bsum_new = SumMax[VOL_W-1:0];
        end
        else if (bsum_wide < SumMin) begin
            bsum_new = SumMin[VOL_W-1:0];
        end
        else begin
            bsum_new = bsum_wide[VOL_W-1:0];
        end
        bcnt_new = (active && band_cnt_reg < CountCapL) ? band_cnt_reg + 1'b1 : band_cnt_reg;
        pcnt_new = (active && point_cnt_reg < CountCapL) ? point_cnt_reg + 1'b1 : point_cnt_reg;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        pair_next  = pair_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_beat) begin
                    state_next = ST_MUL;
                    op_next    = OP_MF0;
                    pair_next  = 2'd0;
                end
            end
            ST_MUL:
            begin
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                state_next = ST_MUL;
                unique case (op_reg)
                    OP_MF0:    op_next = OP_MF1;
                    OP_MF1:    op_next = OP_M0_LO;
                    OP_M0_LO:  op_next = OP_M0_HI;
                    OP_M0_HI:  op_next = OP_M1_LO;
                    OP_M1_LO:  op_next = OP_M1_HI;
                    OP_M1_HI:  state_next = ST_CHECK;
                    OP_TERM:
                    begin
                        if (pair_reg == 2'd3) begin
                            state_next = ST_SCALE;
                        end
                        else begin
                            state_next = ST_CHECK;
                            pair_next  = pair_reg + 2'd1;
                        end
                    end
                    OP_VOL_LO: op_next = OP_VOL_HI;
                    OP_VOL_HI: state_next = ST_SIGN;
                    default:   state_next = ST_IDLE;
                endcase
            end
            ST_CHECK:
            begin
                if (pair_taken) begin
                    state_next = ST_SQRT;
                end
                else if (pair_reg == 2'd3) begin
                    state_next = ST_SCALE;
                end
                else begin
                    pair_next = pair_reg + 2'd1;
                end
            end
            ST_SQRT:
            begin
                // last cycle steps the 4 and 1 root weights
                if (sq_one_reg[2]) begin
                    state_next = ST_MUL;
                    op_next    = OP_TERM;
                end
            end
            ST_SCALE:
            begin
                if (sum_reg == '0) begin
                    state_next = ST_DONE;
                end
                else begin
                    state_next = ST_MUL;
                    op_next    = OP_VOL_LO;
                end
            end
            ST_SIGN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (slot_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs of the sequencer: handshake and multiplier operands
    always_comb
    begin
        item.ready = (state_reg == ST_IDLE);
        mul_a      = '0;
        mul_b      = '0;
        unique case (op_reg)
            OP_MF0:
            begin
                mul_a = {1'b0, mlo_reg};
                mul_b = {1'b0, fld_reg};
            end
            OP_MF1:
            begin
                mul_a = {1'b0, mhi_reg};
                mul_b = {1'b0, fld_reg};
            end
            OP_M0_LO:
            begin
                mul_a = mf0_reg[31:0];
                mul_b = irf_reg;
            end
            OP_M0_HI:
            begin
                mul_a = {18'd0, mf0_reg[45:32]};
                mul_b = irf_reg;
            end
            OP_M1_LO:
            begin
                mul_a = mf1_reg[31:0];
                mul_b = irf_reg;
            end
            OP_M1_HI:
            begin
                mul_a = {18'd0, mf1_reg[45:32]};
                mul_b = irf_reg;
            end
            OP_TERM:
            begin
                mul_a = d_reg;
                mul_b = {8'd0, sq_reg.root[23:0]};
            end
            OP_VOL_LO:
            begin
                mul_a = mag_reg[31:0];
                mul_b = VOL_COEFF_Q16;
            end
            OP_VOL_HI:
            begin
                mul_a = {22'd0, mag_reg[41:32]};
                mul_b = VOL_COEFF_Q16;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            op_reg    <= OP_MF0;
            pair_reg  <= 2'd0;
        end
        else begin
            state_reg <= state_next;
            op_reg    <= op_next;
            pair_reg  <= pair_next;
        end
    end

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            irf_reg <= INV_REF_FIELD_RESET;
        end
        else if (cfg_wr_en) begin
            irf_reg <= cfg_wr_data;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (item_beat) begin
                    k0_reg         <= {item.band_low_energy[31], item.band_low_energy} -
                                      {item.potential[31], item.potential};
                    k1_reg         <= {item.band_high_energy[31], item.band_high_energy} -
                                      {item.potential[31], item.potential};
                    mlo_reg        <= item.moment_low;
                    mhi_reg        <= item.moment_high;
                    fld_reg        <= item.field_strength;
                    last_band_reg  <= item.last_in_band;
                    last_point_reg <= item.last_in_point;
                    sum_reg        <= '0;
                    status_reg     <= '0;
                end
            end
            ST_MUL:
            begin
                prod_reg <= mul_a * mul_b;
            end
            ST_ACC:
            begin
                case (op_reg)
                    OP_MF0:    mf0_reg <= prod_reg[61:16];
                    OP_MF1:    mf1_reg <= prod_reg[61:16];
                    OP_M0_LO:  acc_reg <= {14'd0, prod_reg};
                    OP_M0_HI:  m0_reg  <= acc_sum[77:16];
                    OP_M1_LO:  acc_reg <= {14'd0, prod_reg};
                    OP_M1_HI:  m1_reg  <= acc_sum[77:16];
                    OP_TERM:
                    begin
                        if (term_neg_reg) begin
                            sum_reg <= sum_reg - $signed({3'b000, prod_reg[55:16]});
                        end
                        else begin
                            sum_reg <= sum_reg + $signed({3'b000, prod_reg[55:16]});
                        end
                        status_reg <= status_reg + 1'b1;
                    end
                    OP_VOL_LO: acc_reg     <= {14'd0, prod_reg} + ROUND_HALF;
                    OP_VOL_HI: vol_mag_reg <= acc_sum[60:16];
                    default:   acc_reg     <= acc_reg;
                endcase
            end
            ST_CHECK:
            begin
                d_reg          <= d_val;
                term_neg_reg   <= (pair_reg[0] == pair_reg[1]);
                sq_reg.rem     <= {d_val, 16'd0};
                sq_reg.root    <= '0;
                sq_one_reg     <= 48'd1 << 46;
            end
            ST_SQRT:
            begin
                sq_reg     <= sq_step2;
                sq_one_reg <= sq_one_reg >> 4;
            end
            ST_SCALE:
            begin
                sum_neg_reg <= sum_reg[42];
                mag_reg     <= sum_reg[42] ? 42'(-sum_reg) : sum_reg[41:0];
                vol_reg     <= '0;
            end
            ST_SIGN:
            begin
                vol_reg <= sum_neg_reg ? -$signed({3'b000, vol_mag_reg})
                                       : $signed({3'b000, vol_mag_reg});
            end
            default:
            begin
                prod_reg <= prod_reg;
            end
        endcase
    end

    // running totals, reported and cleared at band and point ends
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            band_sum_reg  <= '0;
            band_cnt_reg  <= '0;
            point_cnt_reg <= '0;
        end
        else if (state_reg == ST_DONE && slot_free) begin
            band_sum_reg  <= band_end ? '0 : bsum_new;
            band_cnt_reg  <= band_end ? '0 : bcnt_new;
            point_cnt_reg <= last_point_reg ? '0 : pcnt_new;
        end
    end

    // result slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == ST_DONE && slot_free) begin
            out_valid_reg <= 1'b1;
        end
        else if (result_beat) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DONE && slot_free) begin
            out_vol_reg        <= vol_reg;
            out_status_reg     <= status_reg;
            out_band_vol_reg   <= band_end ? bsum_new : '0;
            out_band_cnt_reg   <= band_end ? bcnt_new : '0;
            out_point_cnt_reg  <= last_point_reg ? pcnt_new : '0;
            out_band_done_reg  <= band_end;
            out_point_done_reg <= last_point_reg;
        end
    end

    assign result.valid              = out_valid_reg;
    assign result.cell_volume        = out_vol_reg;
    assign result.cell_status        = out_status_reg;
    assign result.band_volume        = out_band_vol_reg;
    assign result.band_active_cells  = out_band_cnt_reg;
    assign result.point_active_cells = out_point_cnt_reg;
    assign result.band_done          = out_band_done_reg;
    assign result.point_done         = out_point_done_reg;

    // checks
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.cell_status <= 3'd4))
        else $error("cell status above four");

    a_inactive_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.cell_status == '0) |-> (result.cell_volume == '0))
        else $error("inactive cell with nonzero volume");

    a_point_ends_band: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.point_done) |-> result.band_done)
        else $error("point end without band end");

    a_band_totals_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.band_done) |->
            (result.band_volume == '0 && result.band_active_cells == '0))
        else $error("band totals shown before band end");

    a_busy_after_item: assert property (@(posedge clk) disable iff (!rst_n)
        item_beat |=> !item.ready)
        else $error("second item taken while a cell is in work");

endmodule

>>> sim/cell_volume_checker.sv
// ----------------------------------------------------------------------------
// cell_volume_checker
// watches the item, result and register ports of the phase volume cell
// classifier, predicts every result beat from the accepted item beats and
// compares each field; mismatches and beats still owed go back to the bench
// ----------------------------------------------------------------------------
module cell_volume_checker
    import pvcc_pkg::*;
#(
    parameter int unsigned MAX_CELLS_PER_POINT = MAX_CELLS_DEFAULT
)(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data,
    pvcc_item_if             item,
    pvcc_result_if           result,
    output int               mismatches,
    output int               outstanding
);

    localparam longint VOL_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint VOL_MIN = -VOL_MAX - 1;
    // 4*pi/3*sqrt(2) in Q16.16
    localparam longint unsigned VOLUME_COEFF = 388225;
    localparam int unsigned COUNT_CAP =
        (MAX_CELLS_PER_POINT < COUNT_SAT_MAX) ? MAX_CELLS_PER_POINT : COUNT_SAT_MAX;

    typedef struct packed {
        logic signed [VOL_W-1:0]    cell_volume;
        logic        [STATUS_W-1:0] cell_status;
        logic signed [VOL_W-1:0]    band_volume;
        logic        [COUNT_W-1:0]  band_active_cells;
        logic        [COUNT_W-1:0]  point_active_cells;
        logic                       band_done;
        logic                       point_done;
    } cell_result_t;

    logic [CFG_W-1:0] inv_field;
    longint           band_sum;
    int unsigned      band_count;
    int unsigned      point_count;
    cell_result_t     expected_q[$];

    // moment * field * inverse reference field, Q16.16, no loss of high bits
    function automatic longint unsigned scaled_moment(input logic [MOMENT_W-1:0] moment,
                                                      input logic [MOMENT_W-1:0] fld);
        longint unsigned prod, whole, frac;
        prod  = (64'(moment) * 64'(fld)) >> 16;
        whole = prod >> 16;
        frac  = prod & 64'hFFFF;
        return whole * 64'(inv_field) + ((frac * 64'(inv_field)) >> 16);
    endfunction

    // floor of the square root, argument below 2^48
    function automatic longint unsigned root_floor(input longint unsigned x);
        longint unsigned r, trial;
        r = 0;
        for (int b = 23; b >= 0; b--)
        begin
            trial = r | (64'd1 << b);
            if (trial * trial <= x)
                r = trial;
        end
        return r;
    endfunction

    // (kinetic - bound)^1.5 in Q16.16 when the pair is taken
    function automatic bit pair_term(input longint kinetic, input longint unsigned bound,
                                     output longint unsigned term);
        longint unsigned gap;
        term = 0;
        if (kinetic <= 0 || signed'(bound) >= kinetic)
            return 1'b0;
        gap  = unsigned'(kinetic) - bound;
        term = (gap * root_floor(gap << 16)) >> 16;
        return 1'b1;
    endfunction

    function automatic longint clamp_volume(input longint v);
        if (v > VOL_MAX)
            return VOL_MAX;
        if (v < VOL_MIN)
            return VOL_MIN;
        return v;
    endfunction

    // one cell in, one result out; updates the band and point totals
    function automatic cell_result_t predict_cell(
        input logic signed [ENERGY_W-1:0] e_lo,
        input logic signed [ENERGY_W-1:0] e_hi,
        input logic signed [ENERGY_W-1:0] pot,
        input logic [MOMENT_W-1:0]        m_lo,
        input logic [MOMENT_W-1:0]        m_hi,
        input logic [MOMENT_W-1:0]        fld,
        input logic                       lb,
        input logic                       lp
    );
        longint          k_lo, k_hi, sum, vol;
        longint unsigned b_lo, b_hi, t, mag;
        int unsigned     pairs;
        bit              band_end;
        cell_result_t    r;

        k_lo     = longint'(e_lo) - longint'(pot);
        k_hi     = longint'(e_hi) - longint'(pot);
        b_lo     = scaled_moment(m_lo, fld);
        b_hi     = scaled_moment(m_hi, fld);
        band_end = lb || lp;
        sum      = 0;
        pairs    = 0;
        vol      = 0;

        if (pair_term(k_lo, b_lo, t))
        begin
            sum -= signed'(t);
            pairs++;
        end
        if (pair_term(k_hi, b_lo, t))
        begin
            sum += signed'(t);
            pairs++;
        end
        if (pair_term(k_lo, b_hi, t))
        begin
            sum += signed'(t);
            pairs++;
        end
        if (pair_term(k_hi, b_hi, t))
        begin
            sum -= signed'(t);
            pairs++;
        end

        // scale, round half away from zero
        if (sum != 0)
        begin
            mag = unsigned'(sum < 0 ? -sum : sum) * VOLUME_COEFF;
            mag = (mag + 64'h8000) >> 16;
            if (mag > unsigned'(VOL_MAX))
                mag = unsigned'(VOL_MAX);
            vol = (sum < 0) ? -signed'(mag) : signed'(mag);
        end

        if (pairs != 0)
        begin
            band_sum = clamp_volume(band_sum + vol);
            if (band_count < COUNT_CAP)
                band_count++;
            if (point_count < COUNT_CAP)
                point_count++;
        end

        r.cell_volume        = vol[VOL_W-1:0];
        r.cell_status        = pairs[STATUS_W-1:0];
        r.band_volume        = band_end ? band_sum[VOL_W-1:0] : '0;
        r.band_active_cells  = band_end ? COUNT_W'(band_count) : '0;
        r.point_active_cells = lp ? COUNT_W'(point_count) : '0;
        r.band_done          = band_end;
        r.point_done         = lp;

        if (band_end)
        begin
            band_sum   = 0;
            band_count = 0;
        end
        if (lp)
            point_count = 0;
        return r;
    endfunction

    function automatic int field_diff(input string name, input logic [VOL_W-1:0] want,
                                      input logic [VOL_W-1:0] got);
        if (want === got)
            return 0;
        $display("%0t: %s expected %h, got %h", $time, name, want, got);
        return 1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        cell_result_t want;
        if (!rst_n)
        begin
            inv_field   = INV_REF_FIELD_RESET;
            band_sum    = 0;
            band_count  = 0;
            point_count = 0;
            mismatches  = 0;
            expected_q.delete();
        end
        else
        begin
            if (cfg_wr_en)
                inv_field = cfg_wr_data;
            // result first: it belongs to an older cell than any item taken now
            if (result.valid && result.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t: result beat with no cell waiting, expected none, got volume %h",
                             $time, result.cell_volume);
                    mismatches++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    mismatches += field_diff("cell_volume", want.cell_volume,
                                             result.cell_volume);
                    mismatches += field_diff("cell_status", want.cell_status,
                                             result.cell_status);
                    mismatches += field_diff("band_volume", want.band_volume,
                                             result.band_volume);
                    mismatches += field_diff("band_active_cells", want.band_active_cells,
                                             result.band_active_cells);
                    mismatches += field_diff("point_active_cells", want.point_active_cells,
                                             result.point_active_cells);
                    mismatches += field_diff("band_done", want.band_done, result.band_done);
                    mismatches += field_diff("point_done", want.point_done, result.point_done);
                end
            end
            if (item.valid && item.ready)
            begin
                want = predict_cell(item.band_low_energy, item.band_high_energy,
                                    item.potential, item.moment_low,
                                    item.moment_high, item.field_strength,
                                    item.last_in_band, item.last_in_point);
                expected_q = {expected_q, want};
            end
        end
        outstanding = expected_q.size();
    end

endmodule

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// drives the phase volume cell classifier with directed corner cells, random
// bands of cells under several inverse reference field settings and one
// crowded point that runs the counts into saturation; both sides of the
// valid/ready channels idle at random, and a checker beside the block
// predicts and compares every result beat
// ----------------------------------------------------------------------------
module tb;
    import pvcc_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    // receiver hold-off, long enough to back the block up into its input
    localparam int LONG_HOLD   = 400;
    // random beats per register setting, at the least
    localparam int PHASE_CELLS = 4;
    // active cells in the crowded point, past the count ceiling
    localparam int CROWD_CELLS = 1030;

    logic             clk;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [CFG_W-1:0] cfg_wr_data;

    int mismatches;
    int outstanding;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_requests = 0;
    int cells_sent    = 0;
    int cycle_count   = 0;

    pvcc_item_if   item_ch ();
    pvcc_result_if result_ch ();

    phase_volume_cell_classifier_top uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item        (item_ch),
        .result      (result_ch)
    );

    cell_volume_checker volume_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item        (item_ch),
        .result      (result_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog: a hung handshake ends the run here
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: cycle limit reached with %0d result beats owed", $time, outstanding);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // result side: random ready, plus a long hold-off whenever one is requested
    initial
    begin : result_sink
        int hold_left;
        int holds_done;
        hold_left        = 0;
        holds_done       = 0;
        result_ch.ready  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left == 0 && holds_done < hold_requests)
            begin
                hold_left = LONG_HOLD;
                holds_done++;
            end
            if (hold_left != 0)
            begin
                result_ch.ready <= 1'b0;
                hold_left--;
            end
            else
                result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // one item beat; random idle cycles first, returns at the accepting edge
    task automatic send_cell(input logic [31:0] e_lo, e_hi, pot,
                             input logic [30:0] m_lo, m_hi, fld,
                             input logic lb, lp);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid            <= 1'b1;
        item_ch.band_low_energy  <= e_lo;
        item_ch.band_high_energy <= e_hi;
        item_ch.potential        <= pot;
        item_ch.moment_low       <= m_lo;
        item_ch.moment_high      <= m_hi;
        item_ch.field_strength   <= fld;
        item_ch.last_in_band     <= lb;
        item_ch.last_in_point    <= lp;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        cells_sent++;
    endtask

    // band of cells with the largest volume of one sign, enough to clip the band sum
    task automatic send_heavy_band();
        bit          neg;
        logic [31:0] top;
        neg = $urandom_range(1);
        for (int i = 0; i < 26; i++)
        begin
            top = 32'h7FFF_FFFF - $urandom_range(255);
            // potential at the bottom: one edge gives no kinetic energy, the other nearly 2^32
            send_cell(neg ? top : 32'h8000_0000, neg ? 32'h8000_0000 : top, 32'h8000_0000,
                      '0, '1, '1, i == 25, 1'b0);
        end
    endtask

    task automatic write_inv_field(input logic [CFG_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // drop valid and let every owed result beat come out
    task automatic wait_for_drain();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [31:0] edge_word();
        case ($urandom_range(5))
            0:       return 32'h0000_0000;
            1:       return 32'h0000_0001;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h8000_0000;
            4:       return 32'h7FFF_FFFF;
            default: return 32'h0001_0000;
        endcase
    endfunction

    initial
    begin : stimulus
        logic [CFG_W-1:0] inv_settings [9];
        logic [31:0]      pot, e_lo, e_hi, e_tmp;
        logic [30:0]      m_lo, m_hi, fld, m_tmp;
        int               phase_end, pick, cells, sh_e, sh_m, sh_f;
        bit               lp;

        // every block input known from time zero
        rst_n                    = 1'b0;
        cfg_wr_en                = 1'b0;
        cfg_wr_data              = '0;
        item_ch.valid            = 1'b0;
        item_ch.band_low_energy  = '0;
        item_ch.band_high_energy = '0;
        item_ch.potential        = '0;
        item_ch.moment_low       = '0;
        item_ch.moment_high      = '0;
        item_ch.field_strength   = '0;
        item_ch.last_in_band     = 1'b0;
        item_ch.last_in_point    = 1'b0;
        send_idle_pct            = 0;
        recv_idle_pct            = 0;

        // 1.0, zero, all ones, one lsb, then a few in between
        inv_settings = '{32'h0001_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
                         32'h0000_0000, 32'h0000_4000, 32'h0000_0000, 32'h0002_0000,
                         32'h0001_0000};
        inv_settings[4] = $urandom;
        inv_settings[6] = $urandom;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed cells at the reset setting (1.0) ----
        // all zero: inactive
        send_cell(32'h0, 32'h0, 32'h0, '0, '0, '0, 1'b0, 1'b0);
        // all fields at their top: no kinetic energy
        send_cell(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '1, '1, '1, 1'b0, 1'b0);
        // all four pairs taken, terms cancel to zero volume
        send_cell(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, '0, '0, '0, 1'b0, 1'b0);
        // energies at the bottom, potential at the top: deeply negative kinetic
        send_cell(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, '1, '1, '1, 1'b0, 1'b0);
        // one pair: upper edge above the low moment only
        send_cell(32'h0, 32'h000A_0000, 32'h0, '0, 31'h0064_0000, 31'h0001_0000, 1'b0, 1'b0);
        // two pairs
        send_cell(32'h0005_0000, 32'h000A_0000, 32'h0, 31'h0001_0000, 31'h0064_0000,
                  31'h0001_0000, 1'b0, 1'b0);
        // three pairs
        send_cell(32'h0005_0000, 32'h000A_0000, 32'h0, 31'h0001_0000, 31'h0007_0000,
                  31'h0001_0000, 1'b0, 1'b0);
        // four pairs with a real volume, closes the band
        send_cell(32'h0014_0000, 32'h001E_0000, 32'h0, 31'h0001_0000, 31'h0002_0000,
                  31'h0001_0000, 1'b1, 1'b0);
        // kinetic exactly equal to the moment bound is not taken, one lsb above is
        send_cell(32'h0001_0000, 32'h0001_0001, 32'hFFFE_0000, 31'h0001_8000, 31'h0001_8000,
                  31'h0002_0000, 1'b0, 1'b0);
        // largest positive volume, band end
        send_cell(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, '0, '1, '1, 1'b1, 1'b0);
        // largest negative volume, point end marked without the band-end mark
        send_cell(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, '0, '1, '1, 1'b0, 1'b1);
        // inactive cell closing a band: empty totals
        send_cell(32'h0, 32'h0, 32'h0001_0000, '0, '0, '0, 1'b1, 1'b0);
        // active cell with both ends marked
        send_cell(32'h0005_0000, 32'h000A_0000, 32'h0, 31'h0001_0000, 31'h0064_0000,
                  31'h0001_0000, 1'b1, 1'b1);
        // huge moment bounds against the largest kinetic energy
        send_cell(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, '1, '1, '1, 1'b0, 1'b0);
        // inverted edges and negative potential
        send_cell(32'h0003_0000, 32'hFFFF_0000, 32'hFFF0_0000, 31'h0000_8000, 31'h0000_1000,
                  31'h0000_C000, 1'b0, 1'b1);
        wait_for_drain();

        // ---- random bands, one register setting per phase ----
        for (int phase = 0; phase < 9; phase++)
        begin
            case (phase / 3)
                0:
                begin
                    send_idle_pct = 21;
                    recv_idle_pct = 47;
                end
                1:
                begin
                    send_idle_pct = 47;
                    recv_idle_pct = 21;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            write_inv_field(inv_settings[phase]);
            // long receiver stall while the sender keeps offering beats
            if (phase % 4 == 0)
                hold_requests++;
            if (phase == 0)
                send_heavy_band();
            phase_end = cells_sent + PHASE_CELLS;
            while (cells_sent < phase_end)
            begin
                pick = $urandom_range(99);
                if (pick < 4)
                    send_heavy_band();
                else if (pick < 74)
                begin
                    // a well-formed band: kinetic and moment scales drawn per cell so
                    // that every number of taken pairs shows up
                    cells = $urandom_range(1, 8);
                    for (int i = 0; i < cells; i++)
                    begin
                        sh_e = $urandom_range(4, 30);
                        sh_m = $urandom_range(4, 22);
                        sh_f = $urandom_range(4, 20);
                        pot  = ($urandom & ((32'd1 << sh_e) - 1)) - (32'd1 << (sh_e - 1));
                        e_lo = pot + ($urandom & ((32'd1 << sh_e) - 1)) - (32'd1 << (sh_e - 2));
                        e_hi = e_lo + ($urandom & ((32'd1 << sh_e) - 1));
                        m_lo = 31'($urandom & ((32'd1 << sh_m) - 1));
                        m_hi = m_lo + 31'($urandom & ((32'd1 << sh_m) - 1));
                        fld  = 31'($urandom & ((32'd1 << sh_f) - 1));
                        // now and then the edges come in the wrong order
                        if ($urandom_range(9) == 0)
                        begin
                            e_tmp = e_lo;
                            e_lo  = e_hi;
                            e_hi  = e_tmp;
                        end
                        if ($urandom_range(9) == 0)
                        begin
                            m_tmp = m_lo;
                            m_lo  = m_hi;
                            m_hi  = m_tmp;
                        end
                        // a point may also end in the middle of a band
                        lp = (i == cells - 1) ? ($urandom_range(3) == 0)
                                              : ($urandom_range(19) == 0);
                        send_cell(e_lo, e_hi, pot, m_lo, m_hi, fld, i == cells - 1, lp);
                    end
                end
                else if (pick < 88)
                    // noise: every bit of every field free
                    send_cell($urandom, $urandom, $urandom, 31'($urandom), 31'($urandom),
                              31'($urandom), 1'($urandom_range(1)), 1'($urandom_range(1)));
                else
                    send_cell(edge_word(), edge_word(), edge_word(), 31'(edge_word()),
                              31'(edge_word()), 31'(edge_word()), 1'($urandom_range(1)),
                              1'($urandom_range(1)));
            end
            wait_for_drain();
        end

        // ---- one crowded point: every cell active, no band or point end until the
        // last, so both counts climb into their ceiling ----
        write_inv_field($urandom);
        for (int i = 0; i < CROWD_CELLS; i++)
            send_cell($urandom, $urandom_range(32'h7FFF_FFFF, 1), 32'h0, '0, 31'($urandom),
                      31'($urandom), 1'b0, i == CROWD_CELLS - 1);
        wait_for_drain();

        // settle past the block's latency before the verdict
        repeat (100) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/pvcc_pkg.sv
rtl/core/pvcc_if.sv
rtl/core/phase_volume_cell_classifier_top.sv
sim/cell_volume_checker.sv
sim/tb.sv
